@@ rtl/m4vt_pkg.sv @@
`default_nettype none

package m4vt_pkg;

    // field widths fixed by the interface
    localparam int DATA_W   = 32;
    localparam int LANES    = 4;
    localparam int COL_W    = 2;
    localparam int FORM_W   = 2;

    // arithmetic widths: full product, pair sum, rounded row sum
    localparam int PROD_W   = 2 * DATA_W;
    localparam int PAIR_W   = PROD_W + 1;
    localparam int SUM_W    = PROD_W + 3;

    // defaults for the top level parameters
    localparam int DIM_DEFAULT       = 4;
    localparam int FRAC_BITS_DEFAULT = 16;

    // queue depths
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 8;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } opcode_t;

    typedef enum logic [FORM_W-1:0]
    {
        FORM_VEC4   = 2'd0,
        FORM_POINT3 = 2'd1,
        FORM_POINT2 = 2'd2
    } form_t;

    // classified command handed from front to back
    typedef struct packed
    {
        opcode_t                       op;
        logic [COL_W-1:0]              col;
        logic [LANES-1:0][DATA_W-1:0]  vec;
    } cmd_t;

    // finished transform result
    typedef struct packed
    {
        logic [LANES-1:0][DATA_W-1:0]  res;
        logic                          ovf;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/m4vt_fifo.sv @@
`default_nettype none

module m4vt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [WIDTH-1:0]             wr_data,
    input  wire logic                         rd_en,
    output logic      [WIDTH-1:0]             rd_data,
    output logic                              full,
    output logic                              empty,
    output logic      [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/m4vt_front.sv @@
`default_nettype none

module m4vt_front #(
    parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic                               opcode,
    input  wire logic [m4vt_pkg::COL_W-1:0]         column_index,
    input  wire logic [m4vt_pkg::FORM_W-1:0]        form,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] in_x,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] in_y,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] in_z,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] in_w,
    output logic                                    cmd_push,
    output m4vt_pkg::cmd_t                          cmd,
    input  wire logic                               cmd_full
);

    localparam logic [m4vt_pkg::DATA_W-1:0] ONE_FIXED =
        m4vt_pkg::DATA_W'(1) << FRAC_BITS;

    logic            valid_reg, valid_next;
    m4vt_pkg::cmd_t  cmd_reg;
    m4vt_pkg::cmd_t  cmd_next;
    logic            accept;

    assign full     = valid_reg && cmd_full;
    assign accept   = push && !full;
    assign cmd_push = valid_reg;
    assign cmd      = cmd_reg;

    // classify: loads pass as given, transforms get their form applied
    always_comb
    begin
        cmd_next.op     = m4vt_pkg::opcode_t'(opcode);
        cmd_next.col    = column_index;
        cmd_next.vec[0] = in_x;
        cmd_next.vec[1] = in_y;
        cmd_next.vec[2] = in_z;
        cmd_next.vec[3] = in_w;
        if (cmd_next.op == m4vt_pkg::OP_XFORM)
        begin
            unique case (m4vt_pkg::form_t'(form))
                m4vt_pkg::FORM_POINT3:
                begin
                    cmd_next.vec[3] = ONE_FIXED;
                end
                m4vt_pkg::FORM_POINT2:
                begin
                    cmd_next.vec[2] = '0;
                    cmd_next.vec[3] = ONE_FIXED;
                end
                default:
                begin
                    cmd_next.vec[3] = in_w;
                end
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !cmd_full)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/m4vt_back.sv @@
`default_nettype none

module m4vt_back #(
    parameter int DIM       = m4vt_pkg::DIM_DEFAULT,
    parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire m4vt_pkg::cmd_t                             cmd,
    input  wire logic                                       cmd_empty,
    output logic                                            cmd_pop,
    input  wire logic [$clog2(m4vt_pkg::RES_DEPTH+1)-1:0]   res_count,
    output logic                                            res_push,
    output m4vt_pkg::result_t                               res
);

    localparam int DW    = m4vt_pkg::DATA_W;
    localparam int LN    = m4vt_pkg::LANES;
    localparam int PW    = m4vt_pkg::PROD_W;
    localparam int AW    = m4vt_pkg::PAIR_W;
    localparam int SW    = m4vt_pkg::SUM_W;
    localparam int CNT_W = $clog2(m4vt_pkg::RES_DEPTH + 1);
    localparam logic [SW-1:0] HALF_FIXED = SW'(1) << (FRAC_BITS - 1);

    logic [DW-1:0]        matrix_reg [DIM][DIM];   // [column][row]
    logic signed [PW-1:0] prod_next  [LN][LN];     // [row][column]
    logic signed [PW-1:0] prod_reg   [LN][LN];
    logic signed [AW-1:0] pair_reg   [LN][2];
    logic signed [SW-1:0] sum_reg    [LN];
    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [CNT_W:0]       pending;
    logic                 has_room;
    logic                 do_load;
    logic                 do_xform;
    logic [LN-1:0]        row_ovf;

    // reserve a result slot for every transform in flight
    assign pending  = (CNT_W + 1)'(res_count) + (CNT_W + 1)'(s1_valid_reg)
                    + (CNT_W + 1)'(s2_valid_reg) + (CNT_W + 1)'(s3_valid_reg);
    assign has_room = pending < (CNT_W + 1)'(m4vt_pkg::RES_DEPTH);

    assign do_load  = !cmd_empty && (cmd.op == m4vt_pkg::OP_LOAD);
    assign do_xform = !cmd_empty && (cmd.op == m4vt_pkg::OP_XFORM) && has_room;
    assign cmd_pop  = do_load || do_xform;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < DIM; c++)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                if (do_load && cmd.col == m4vt_pkg::COL_W'(c))
                begin
                    matrix_reg[c][r] <= cmd.vec[r];
                end
            end
        end
    end

    // one multiplier per matrix entry, unused size gives zero
    for (genvar r = 0; r < LN; r++)
    begin : g_row
        for (genvar c = 0; c < LN; c++)
        begin : g_col
            if (r < DIM && c < DIM)
            begin : g_mul
                assign prod_next[r][c] = $signed(matrix_reg[c][r]) * $signed(cmd.vec[c]);
            end
            else
            begin : g_zero
                assign prod_next[r][c] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= do_xform;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < LN; r++)
        begin
            for (int c = 0; c < LN; c++)
            begin
                prod_reg[r][c] <= prod_next[r][c];
            end
            pair_reg[r][0] <= AW'(prod_reg[r][0]) + AW'(prod_reg[r][1]);
            pair_reg[r][1] <= AW'(prod_reg[r][2]) + AW'(prod_reg[r][3]);
            sum_reg[r]     <= SW'(pair_reg[r][0]) + SW'(pair_reg[r][1]) + HALF_FIXED;
        end
    end

    // shift and saturate each rounded row sum
    always_comb
    begin
        logic signed [SW-1:0] shifted;
        logic [SW-DW:0]       upper;
        for (int r = 0; r < LN; r++)
        begin
            shifted = sum_reg[r] >>> FRAC_BITS;
            upper   = shifted[SW-1:DW-1];
            if (&upper || !(|upper))
            begin
                res.res[r] = shifted[DW-1:0];
                row_ovf[r] = 1'b0;
            end
            else
            begin
                res.res[r] = sum_reg[r][SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
                row_ovf[r] = 1'b1;
            end
        end
        res.ovf = |row_ovf;
    end

    assign res_push = s3_valid_reg;

endmodule

`default_nettype wire

@@ rtl/matrix4_vector_transform.sv @@
// an accepted transform passes the input stage, command queue, multiply, pair add,
//   final add and round stages and the result queue before showing on the result ports
// throughput: one transaction per cycle, sustained while results are popped as they come
// load transactions write one matrix column in the back end and give no result
// reset: rst_n asynchronous active low clears both queues and all valid flags;
//   the matrix is not cleared and must be loaded before a transform reads it
`default_nettype none

module matrix4_vector_transform #(
    parameter int DIM       = m4vt_pkg::DIM_DEFAULT,
    parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input queue side
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic                               opcode,
    input  wire logic [m4vt_pkg::COL_W-1:0]         column_index,
    input  wire logic [m4vt_pkg::FORM_W-1:0]        form,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] in_x,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] in_y,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] in_z,
    input  wire logic signed [m4vt_pkg::DATA_W-1:0] in_w,
    // result queue side
    output logic                                    empty,
    input  wire logic                               pop,
    output logic signed [m4vt_pkg::DATA_W-1:0]      out_x,
    output logic signed [m4vt_pkg::DATA_W-1:0]      out_y,
    output logic signed [m4vt_pkg::DATA_W-1:0]      out_z,
    output logic signed [m4vt_pkg::DATA_W-1:0]      out_w,
    output logic                                    overflow
);

    localparam int CMD_W     = $bits(m4vt_pkg::cmd_t);
    localparam int RES_W     = $bits(m4vt_pkg::result_t);
    localparam int CMD_CNT_W = $clog2(m4vt_pkg::CMD_DEPTH + 1);
    localparam int RES_CNT_W = $clog2(m4vt_pkg::RES_DEPTH + 1);

    // front to command queue
    logic                    fe_push;
    m4vt_pkg::cmd_t          fe_cmd;
    logic                    cmdq_full;
    // command queue to back end
    m4vt_pkg::cmd_t          cmdq_head;
    logic                    cmdq_empty;
    logic                    be_pop;
    logic [CMD_CNT_W-1:0]    cmdq_count;
    // back end to result queue
    logic                    be_push;
    m4vt_pkg::result_t       be_res;
    m4vt_pkg::result_t       resq_head;
    logic                    resq_full;
    logic [RES_CNT_W-1:0]    resq_count;

    // front: takes a transaction, applies the 2d/3d form, holds it for the queue
    m4vt_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .column_index (column_index),
        .form         (form),
        .in_x         (in_x),
        .in_y         (in_y),
        .in_z         (in_z),
        .in_w         (in_w),
        .cmd_push     (fe_push),
        .cmd          (fe_cmd),
        .cmd_full     (cmdq_full)
    );

    // short command queue, keeps loads and transforms in order
    m4vt_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (m4vt_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_push),
        .wr_data (fe_cmd),
        .rd_en   (be_pop),
        .rd_data (cmdq_head),
        .full    (cmdq_full),
        .empty   (cmdq_empty),
        .count   (cmdq_count)
    );

    // back end: matrix registers and the multiply, add, round pipeline;
    // it only starts a transform when a result slot is free
    m4vt_back #(
        .DIM       (DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmdq_head),
        .cmd_empty (cmdq_empty),
        .cmd_pop   (be_pop),
        .res_count (resq_count),
        .res_push  (be_push),
        .res       (be_res)
    );

    // result queue, decouples the pipeline from the consumer
    m4vt_fifo #(
        .WIDTH (RES_W),
        .DEPTH (m4vt_pkg::RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (be_push),
        .wr_data (be_res),
        .rd_en   (pop),
        .rd_data (resq_head),
        .full    (resq_full),
        .empty   (empty),
        .count   (resq_count)
    );

    assign out_x    = resq_head.res[0];
    assign out_y    = resq_head.res[1];
    assign out_z    = resq_head.res[2];
    assign out_w    = resq_head.res[3];
    assign overflow = resq_head.ovf;

    // command queue occupancy and the result queue full flag are kept for debug visibility
    logic unused_status;
    assign unused_status = resq_full ^ (|cmdq_count);

endmodule

`default_nettype wire

@@ rtl/m4vt_checker.sv @@
`default_nettype none

module m4vt_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        full,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [31:0] out_x,
    input  wire logic [31:0] out_y,
    input  wire logic [31:0] out_z,
    input  wire logic [31:0] out_w,
    input  wire logic        overflow
);

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // reset drains the result queue
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty after reset");

    // reset leaves room for a new transaction
    a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
        else $error("full asserted after reset");

    // an overflow flag always comes with a saturated component
    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && overflow) |->
            (out_x == SAT_POS || out_x == SAT_NEG || out_y == SAT_POS || out_y == SAT_NEG ||
             out_z == SAT_POS || out_z == SAT_NEG || out_w == SAT_POS || out_w == SAT_NEG))
        else $error("overflow without a saturated component");

    // a waiting result holds until taken
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(out_x) && $stable(out_y) && $stable(out_z)
             && $stable(out_w) && $stable(overflow)))
        else $error("waiting result changed before pop");

endmodule

bind matrix4_vector_transform m4vt_checker u_m4vt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .out_w    (out_w),
    .overflow (overflow)
);

`default_nettype wire
